// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the DRX sleep state tracker.
// Every check is clocked on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with an implication written in the property itself.
`define DRXST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that applies only while a given condition holds.
`define DRXST_ASSERT_IMP(label, cond, prop, msg) \
	`DRXST_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- sv/drxst_pkg.sv -----
package drxst_pkg;

	// Sizes of the tracker.
	localparam int NUM_UE        = 64;
	localparam int TIMER_BITS    = 16;
	localparam int ACT_BITS      = 7;
	localparam int LEN_BITS      = 16;
	localparam int CNT_BITS      = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int TDATA_IN_BITS = 128;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [LEN_BITS-1:0]   len_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [NUM_UE-1:0]     ue_mask_t;

	// DRX mode of one terminal.
	typedef enum logic [1:0] {
		MODE_LISTEN = 2'd0,
		MODE_ON     = 2'd1,
		MODE_SLEEP  = 2'd2
	} mode_t;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_UES  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INACT_LEN   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_LEN   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_LEN    = 3'd4;

	// Request kinds carried in tuser.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_INIT = 1'b1;

	// Register reset values.
	localparam logic [ACT_BITS-1:0] RST_ACTIVE_UES  = 7'd64;
	localparam len_t                RST_INACT_LEN   = 16'd10;
	localparam cnt_t                RST_SHORT_LIMIT = 8'd2;
	localparam len_t                RST_SHORT_LEN   = 16'd20;
	localparam len_t                RST_LONG_LEN    = 16'd80;

	// Timing registers as every lane sees them.
	typedef struct packed {
		len_t inact_len;
		cnt_t short_limit;
		len_t short_len;
		len_t long_len;
	} cfg_t;

	// Per-lane control for one transfer.
	typedef struct packed {
		logic go;
		logic init;
		logic upd;
	} lane_ctl_t;

	// Fit a length register to the timer width.
	function automatic timer_t fit_timer(input len_t len);
		return timer_t'(len);
	endfunction

endpackage

// ----- sv/drxst_lane.sv -----
module drxst_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  drxst_pkg::cfg_t     cfg,
	input  drxst_pkg::lane_ctl_t ctl,
	input  logic                dl_pend,
	input  logic                ul_pend,
	output logic                awake
);

	drxst_pkg::mode_t  mode_q, mode_d;
	drxst_pkg::timer_t timer_q, timer_d;
	drxst_pkg::cnt_t   cnt_q, cnt_d;

	drxst_pkg::timer_t inact_t, short_t, long_t;
	drxst_pkg::timer_t lst_sel, lst_dec, slp_dec;
	logic              any_pend, lst_exp, slp_exp;

	assign inact_t  = drxst_pkg::fit_timer(cfg.inact_len);
	assign short_t  = drxst_pkg::fit_timer(cfg.short_len);
	assign long_t   = drxst_pkg::fit_timer(cfg.long_len);
	assign any_pend = dl_pend | ul_pend;

	// Listening countdown: traffic reloads the timer before it is decremented.
	assign lst_sel = any_pend ? inact_t : timer_q;
	assign lst_dec = (lst_sel == '0) ? '0 : lst_sel - drxst_pkg::timer_t'(1);
	assign lst_exp = (lst_sel <= drxst_pkg::timer_t'(1));

	// Sleep countdown saturates at zero, which also counts as expiry.
	assign slp_dec = (timer_q == '0) ? '0 : timer_q - drxst_pkg::timer_t'(1);
	assign slp_exp = (timer_q <= drxst_pkg::timer_t'(1));

	// Next mode, timer and short cycle count.
	always_comb begin
		mode_d  = mode_q;
		timer_d = timer_q;
		cnt_d   = cnt_q;
		if (ctl.go && ctl.init) begin
			mode_d  = drxst_pkg::MODE_LISTEN;
			timer_d = inact_t;
			cnt_d   = cfg.short_limit;
		end else if (ctl.go && ctl.upd) begin
			unique case (mode_q)
				drxst_pkg::MODE_ON: begin
					if (any_pend) begin
						mode_d  = drxst_pkg::MODE_LISTEN;
						timer_d = inact_t;
					end else if (cnt_q != '0) begin
						mode_d  = drxst_pkg::MODE_SLEEP;
						timer_d = short_t;
						cnt_d   = cnt_q - drxst_pkg::cnt_t'(1);
					end else begin
						mode_d  = drxst_pkg::MODE_SLEEP;
						timer_d = long_t;
					end
				end
				drxst_pkg::MODE_SLEEP: begin
					if (ul_pend) begin
						mode_d  = drxst_pkg::MODE_LISTEN;
						timer_d = inact_t;
					end else begin
						timer_d = slp_dec;
						if (slp_exp) begin
							mode_d = drxst_pkg::MODE_ON;
						end
					end
				end
				default: begin
					if (lst_exp) begin
						mode_d  = drxst_pkg::MODE_SLEEP;
						timer_d = short_t;
						cnt_d   = cfg.short_limit;
					end else begin
						mode_d  = drxst_pkg::MODE_LISTEN;
						timer_d = lst_dec;
					end
				end
			endcase
		end
	end

	// Awake flag for this subframe, from the mode at the start of the tick and the uplink pending bit.
	always_comb begin
		awake = 1'b0;
		if (ctl.upd && !ctl.init) begin
			awake = (mode_q != drxst_pkg::MODE_SLEEP) || ul_pend;
		end
	end

	// Lane state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= drxst_pkg::MODE_LISTEN;
			timer_q <= drxst_pkg::fit_timer(drxst_pkg::RST_INACT_LEN);
			cnt_q   <= drxst_pkg::RST_SHORT_LIMIT;
		end else begin
			mode_q  <= mode_d;
			timer_q <= timer_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- sv/drxst_out.sv -----
module drxst_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  drxst_pkg::ue_mask_t lane_awake,
	output logic                free,
	output logic                tvalid,
	input  logic                tready,
	output drxst_pkg::ue_mask_t tdata
);

	logic                valid_q;
	drxst_pkg::ue_mask_t mask_q;

	// A new result may enter when the register is empty or being drained.
	assign free   = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = mask_q;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	// Gather the awake bits of all lanes into one result.
	always_ff @(posedge clk) begin
		if (load) begin
			mask_q <= lane_awake;
		end
	end

endmodule

// ----- sv/drx_sleep_state_tracker.sv -----
// Channel   Direction  Signals                         Contents
// s_axis    in         tvalid tready tdata tuser       request and pending masks
// m_axis    out        tvalid tready tdata             awake mask
// cfg       in         valid ready index data          register writes
//
// All UE lanes update in parallel at the transfer edge, and the awake mask
// appears in the output register in the cycle after the transfer.
// A request is taken every cycle as long as the output register drains.
// After reset all UEs are listening with reset timing values, no clearing pass.
// A stalled m_axis holds s_axis_tready low only while the result is held.
`include "assert_macros.svh"

module drx_sleep_state_tracker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// [63:0] downlink_pending, [127:64] uplink_pending
	input  logic [drxst_pkg::TDATA_IN_BITS-1:0]        s_axis_tdata,
	// [0] req_type
	input  logic                                       s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// [63:0] awake_mask
	output logic [drxst_pkg::NUM_UE-1:0]               m_axis_tdata,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [drxst_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [drxst_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

	logic [drxst_pkg::ACT_BITS-1:0] active_q;
	drxst_pkg::cfg_t                cfg_q;

	logic                s_xfer, req_init;
	drxst_pkg::ue_mask_t dl_mask, ul_mask, upd_mask, awake_lanes;

	assign cfg_ready = 1'b1;
	assign s_xfer    = s_axis_tvalid && s_axis_tready;
	assign req_init  = (s_axis_tuser == drxst_pkg::REQ_INIT);
	assign dl_mask   = s_axis_tdata[drxst_pkg::NUM_UE-1:0];
	assign ul_mask   = s_axis_tdata[2*drxst_pkg::NUM_UE-1:drxst_pkg::NUM_UE];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q          <= drxst_pkg::RST_ACTIVE_UES;
			cfg_q.inact_len   <= drxst_pkg::RST_INACT_LEN;
			cfg_q.short_limit <= drxst_pkg::RST_SHORT_LIMIT;
			cfg_q.short_len   <= drxst_pkg::RST_SHORT_LEN;
			cfg_q.long_len    <= drxst_pkg::RST_LONG_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				drxst_pkg::REG_ACTIVE_UES:  active_q <= cfg_data[drxst_pkg::ACT_BITS-1:0];
				drxst_pkg::REG_INACT_LEN:   cfg_q.inact_len <= cfg_data;
				drxst_pkg::REG_SHORT_LIMIT: cfg_q.short_limit <= cfg_data[drxst_pkg::CNT_BITS-1:0];
				drxst_pkg::REG_SHORT_LEN:   cfg_q.short_len <= cfg_data;
				drxst_pkg::REG_LONG_LEN:    cfg_q.long_len <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// One lane per UE; a lane advances on ticks only below the active count, while init resets every lane.
	for (genvar i = 0; i < drxst_pkg::NUM_UE; i++) begin : g_lane
		drxst_pkg::lane_ctl_t ctl;

		assign upd_mask[i] = (drxst_pkg::ACT_BITS'(i) < active_q);
		assign ctl.go      = s_xfer;
		assign ctl.init    = req_init;
		assign ctl.upd     = upd_mask[i];

		drxst_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.ctl     (ctl),
			.dl_pend (dl_mask[i]),
			.ul_pend (ul_mask[i]),
			.awake   (awake_lanes[i])
		);
	end

	// Result register merging the lane outputs.
	drxst_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s_xfer),
		.lane_awake (awake_lanes),
		.free       (s_axis_tready),
		.tvalid     (m_axis_tvalid),
		.tready     (m_axis_tready),
		.tdata      (m_axis_tdata)
	);

	// An init request leaves an all-zero result behind it.
	`DRXST_ASSERT_IMP(a_init_zero, s_xfer && req_init,
		##1 (m_axis_tvalid && (m_axis_tdata == '0)), "init result not zero")

	// Only lanes below the active count may report awake.
	`DRXST_ASSERT_IMP(a_awake_active, s_xfer,
		##1 ((m_axis_tdata & ~$past(upd_mask)) == '0), "awake bit from idle lane")

	// Every accepted request produces a result in the next cycle.
	`DRXST_ASSERT(a_result_follows, s_xfer |=> m_axis_tvalid, "result missing")

	// A waiting result blocks intake only while it is stalled.
	`DRXST_ASSERT(a_ready_rule, (m_axis_tvalid && m_axis_tready) |-> s_axis_tready,
		"intake blocked while draining")

endmodule
